// ===== rtl/core/rtdb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtdb_pkg: shared types and constants for the RTD bridge converter
// Fixed field widths, bridge conversion constants and the sequencer states.
// ----------------------------------------------------------------------------
package rtdb_pkg;

	// Field widths fixed by the interface
	localparam int unsigned SUM_W  = 16;
	localparam int unsigned TEMP_W = 18;
	localparam int unsigned RES_W  = 16;
	localparam int unsigned CFG_W  = 7;

	localparam logic [CFG_W-1:0] AVG_COUNT_RESET = 7'd25;

	// Multiplier constants; all fit in K_W bits
	localparam int unsigned K_W = 33;
	localparam logic [K_W-1:0] K_DEN  = 33'd470;         // 470 * F * n
	localparam logic [K_W-1:0] K_RES  = 33'd470000;      // resistance numerator scale
	localparam logic [K_W-1:0] K_DEN2 = 33'd77;          // temperature denominator scale
	localparam logic [K_W-1:0] K_TEMP = 33'd4608000000;  // temperature numerator scale

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_DEN,
		ST_MUL_RES,
		ST_MUL_DEN2,
		ST_MUL_TEMP,
		ST_DIV_RES,
		ST_DIV_TEMP,
		ST_WAIT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/rtdb_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtdb_mul: bit-serial shift-add multiplier
// Multiplies a DW-bit operand by a K_W-bit constant, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module rtdb_mul import rtdb_pkg::*; #(
	parameter int unsigned DW = 49
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] a,
	input  wire logic [K_W-1:0] b,
	output logic               done,
	output logic [DW-1:0]      prod
);

	localparam int unsigned IW = $clog2(K_W + 1);

	logic [DW-1:0]  a_q;
	logic [K_W-1:0] b_q;
	logic [DW-1:0]  acc_q;
	logic [IW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= IW'(K_W);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - IW'(1);
			busy_q <= (cnt_q != IW'(1));
			done_q <= (cnt_q == IW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ===== rtl/core/rtdb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtdb_div: restoring radix-2 divider
// Produces one quotient bit a cycle, NW quotient bits per division.
// ----------------------------------------------------------------------------
module rtdb_div #(
	parameter int unsigned NW = 51,
	parameter int unsigned VW = 42
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [VW-1:0] dvs,
	output logic               done,
	output logic [NW-1:0]      quo
);

	localparam int unsigned IW = $clog2(NW + 1);

	logic [NW-1:0] nq_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [IW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	assign trial = {rem_q, nq_q[NW-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= IW'(NW);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - IW'(1);
			busy_q <= (cnt_q != IW'(1));
			done_q <= (cnt_q == IW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the dividend out at the top, the quotient bit in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			nq_q  <= {nq_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule
`default_nettype wire

// ===== rtl/core/rtd_bridge_average_to_temperature_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_bridge_average_to_temperature_unit: PT100 bridge averager and converter
// Sums converter samples and turns each block of samples into probe
// resistance and temperature, both in hundredths, rounded to nearest.
// ----------------------------------------------------------------------------
// Each accepted adc_sample word is added to a saturating 16-bit sum. When the
// number of samples taken reaches average_count (0 acts as 1, values above
// MAX_COUNT act as MAX_COUNT), one result word is produced and the sum and
// count restart. With F = 2^ADC_BITS - 1, n the samples summed, S their sum
// and D = 470*F*n - 48*S, the results are resistance_centi_ohm =
// round(470000*(10*F*n + 48*S) / D) and temperature_centi_c =
// round(4608000000*S / (77*D)), each truncated to its port width.
// Timing: a sample that does not complete a block is added to the sum and
// in_ready stays high. The sample that completes a block starts the
// converter: one setup state, four passes of the bit-serial multiplier
// (K_W = 33 multiplier bits each), two passes of the restoring divider
// (NW = DW+2 quotient bits each, 51 at the default parameters) and a wait
// state that loads the output register. in_ready is low from the accepting
// edge until the converter is idle again; the multiplier passes take most of
// that time. The result sits in an output register while the next block is
// already being summed; a new result waits in the converter until the
// previous one has been taken.
// ----------------------------------------------------------------------------
module rtd_bridge_average_to_temperature_unit import rtdb_pkg::*; #(
	parameter int unsigned ADC_BITS  = 10,
	parameter int unsigned MAX_COUNT = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_wr_en,
	input  wire logic [CFG_W-1:0]    cfg_wr_data,
	// sample input
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ADC_BITS-1:0] adc_sample,
	// result output
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [TEMP_W-1:0]        temperature_centi_c,
	output logic [RES_W-1:0]         resistance_centi_ohm
);

	// Datapath widths follow from the sample width and the block length
	localparam int unsigned CW      = $clog2(MAX_COUNT + 1);
	localparam int unsigned EW      = (CW > CFG_W) ? CW : CFG_W;
	localparam int unsigned FN_W    = ADC_BITS + CW;          // F*n
	localparam int unsigned DEN_W   = FN_W + 9;               // D < 512*F*n
	localparam int unsigned D2_W    = DEN_W + 7;              // 77*D
	localparam int unsigned INNER_W = (((FN_W + 4) > (SUM_W + 6)) ?
	                                   (FN_W + 4) : (SUM_W + 6)) + 1;
	localparam int unsigned DW_A    = INNER_W + 19;           // 470000 < 2^19
	localparam int unsigned DW_B    = SUM_W + K_W;
	localparam int unsigned DW      = (DW_A > DW_B) ? DW_A : DW_B;
	localparam int unsigned NW      = DW + 2;                 // 2*num + den
	localparam int unsigned VW      = D2_W + 1;               // 2*den

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] avg_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q <= AVG_COUNT_RESET;
		end else if (cfg_wr_en) begin
			avg_count_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Accumulator
	// ------------------------------------------------------------------
	logic [CW-1:0]    sample_counter_q;
	logic [SUM_W-1:0] sample_sum_q;
	logic [CW-1:0]    cnt_next;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_next;
	logic [EW-1:0]    cfg_ext;
	logic [EW-1:0]    eff_count;
	logic             block_done;
	logic             in_fire;

	assign cnt_next = sample_counter_q + CW'(1);
	assign sum_wide = {1'b0, sample_sum_q} + (SUM_W + 1)'(adc_sample);
	// Saturate the sum at all ones
	assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

	// Clamp the programmed count into 1..MAX_COUNT
	assign cfg_ext = EW'(avg_count_q);
	always_comb begin
		priority if (cfg_ext == '0) begin
			eff_count = EW'(1);
		end else if (cfg_ext > EW'(MAX_COUNT)) begin
			eff_count = EW'(MAX_COUNT);
		end else begin
			eff_count = cfg_ext;
		end
	end

	assign block_done = (EW'(cnt_next) >= eff_count);
	assign in_fire    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_counter_q <= '0;
			sample_sum_q     <= '0;
		end else if (in_fire) begin
			if (block_done) begin
				sample_counter_q <= '0;
				sample_sum_q     <= '0;
			end else begin
				sample_counter_q <= cnt_next;
				sample_sum_q     <= sum_next;
			end
		end
	end

	// ------------------------------------------------------------------
	// Conversion operands
	// ------------------------------------------------------------------
	logic [FN_W-1:0]  fn_q;        // F * n for the finished block
	logic [SUM_W-1:0] avg_sum_q;   // S for the finished block
	logic [DEN_W-1:0] den_q;
	logic [D2_W-1:0]  den2_q;
	logic [DW-1:0]    res_num_q;
	logic [DW-1:0]    temp_num_q;
	logic [RES_W-1:0] res_q;
	logic [TEMP_W-1:0] temp_q;
	logic [FN_W-1:0]  fn_next;
	logic [DW-1:0]    m48;
	logic [DW-1:0]    inner;
	logic [DW-1:0]    den_full;

	// F*n = (n << ADC_BITS) - n
	assign fn_next  = (FN_W'(cnt_next) << ADC_BITS) - FN_W'(cnt_next);
	assign m48      = (DW'(avg_sum_q) << 5) + (DW'(avg_sum_q) << 4);
	assign inner    = (DW'(fn_q) << 3) + (DW'(fn_q) << 1) + m48;

	// ------------------------------------------------------------------
	// Shared arithmetic units
	// ------------------------------------------------------------------
	logic           mul_start;
	logic [DW-1:0]  mul_a;
	logic [K_W-1:0] mul_b;
	logic           mul_done;
	logic [DW-1:0]  mul_prod;
	logic           div_start;
	logic [NW-1:0]  div_num;
	logic [VW-1:0]  div_dvs;
	logic           div_done;
	logic [NW-1:0]  div_quo;

	assign den_full = mul_prod - m48;

	rtdb_mul #(
		.DW (DW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	rtdb_div #(
		.NW (NW),
		.VW (VW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	state_t state_q;
	state_t state_d;
	logic   load_out;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_dvs   = '0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && block_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				// 470 * F * n
				mul_start = 1'b1;
				mul_a     = DW'(fn_q);
				mul_b     = K_DEN;
				state_d   = ST_MUL_DEN;
			end
			ST_MUL_DEN: begin
				if (mul_done) begin
					// 470000 * (10*F*n + 48*S)
					mul_start = 1'b1;
					mul_a     = inner;
					mul_b     = K_RES;
					state_d   = ST_MUL_RES;
				end
			end
			ST_MUL_RES: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = DW'(den_q);
					mul_b     = K_DEN2;
					state_d   = ST_MUL_DEN2;
				end
			end
			ST_MUL_DEN2: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = DW'(avg_sum_q);
					mul_b     = K_TEMP;
					state_d   = ST_MUL_TEMP;
				end
			end
			ST_MUL_TEMP: begin
				if (mul_done) begin
					// round to nearest: (2*num + den) / (2*den)
					div_start = 1'b1;
					div_num   = NW'({res_num_q, 1'b0}) + NW'(den_q);
					div_dvs   = VW'({den_q, 1'b0});
					state_d   = ST_DIV_RES;
				end
			end
			ST_DIV_RES: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = NW'({temp_num_q, 1'b0}) + NW'(den2_q);
					div_dvs   = VW'({den2_q, 1'b0});
					state_d   = ST_DIV_TEMP;
				end
			end
			ST_DIV_TEMP: begin
				if (div_done) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Capture block operands and intermediate results
	always_ff @(posedge clk) begin
		if (in_fire && block_done) begin
			fn_q      <= fn_next;
			avg_sum_q <= sum_next;
		end
		if (mul_done) begin
			unique case (state_q)
				ST_MUL_DEN:  den_q      <= den_full[DEN_W-1:0];
				ST_MUL_RES:  res_num_q  <= mul_prod;
				ST_MUL_DEN2: den2_q     <= mul_prod[D2_W-1:0];
				ST_MUL_TEMP: temp_num_q <= mul_prod;
				default: ;
			endcase
		end
		if (div_done) begin
			unique case (state_q)
				ST_DIV_RES:  res_q  <= div_quo[RES_W-1:0];
				ST_DIV_TEMP: temp_q <= div_quo[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			temperature_centi_c  <= temp_q;
			resistance_centi_ohm <= res_q;
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Count restarts on reaching the clamped length, so it stays below MAX_COUNT
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_counter_q < CW'(MAX_COUNT))
		else $error("sample counter ran past MAX_COUNT");

	// Multiplier finishes only while the sequencer waits on it
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL_DEN || state_q == ST_MUL_RES ||
		              state_q == ST_MUL_DEN2 || state_q == ST_MUL_TEMP))
		else $error("multiplier done outside a multiply state");

	// Divider finishes only while the sequencer waits on it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_RES || state_q == ST_DIV_TEMP))
		else $error("divider done outside a divide state");

	// Bridge denominator is never zero once division starts
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DIV_RES) |-> (den_q != '0 && den2_q != '0))
		else $error("zero bridge denominator");

	// A new result is loaded only when the previous one has gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$past(load_out))
		else $error("result register overwritten");

endmodule
`default_nettype wire
